// ----- hw/rtl/locality_aware_task_dispatch_defines.svh -----
// Assertion macros for the checker file.
`ifndef LOCALITY_AWARE_TASK_DISPATCH_DEFINES_SVH
`define LOCALITY_AWARE_TASK_DISPATCH_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define LATD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatch check failed");

// The consequent must hold in the same cycle as the antecedent.
`define LATD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatch check failed");

`endif

// ----- hw/rtl/latd_pkg.sv -----
package latd_pkg;

  localparam int RAW_W     = 16;
  localparam int CHUNK_W   = 6;
  localparam int CFG_W     = 5;
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = 4;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 5'd2;
  localparam logic [CFG_W-1:0] NODE_COUNT_MIN   = 5'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic write_home;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

// ----- hw/rtl/latd_ram.sv -----
module latd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/latd_ctrl.sv -----
module latd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              kind,
  output logic              in_stall,
  input  latd_pkg::status_t status,
  output latd_pkg::cmd_t    cmd
);

  import latd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WRITE,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_stall <= 1'b1;
            state    <= (kind == KIND_LOAD) ? S_DIV : S_SCAN;
          end
        end
        S_DIV: begin
          if (status.div_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
        S_SCAN: begin
          if (status.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          // A finished request holds here until the output register is free.
          if (!status.out_busy) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.capture    = in_valid && !in_stall;
    cmd.div_step   = (state == S_DIV);
    cmd.write_home = (state == S_WRITE);
    cmd.scan_step  = (state == S_SCAN);
    cmd.finish     = (state == S_RESULT) && !status.out_busy;
  end

endmodule

// ----- hw/rtl/latd_datapath.sv -----
module latd_datapath #(
  parameter int MAX_CHUNKS = 64,
  parameter int MAX_NODES  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  latd_pkg::cmd_t               cmd,
  output latd_pkg::status_t            status,
  input  logic                         cfg_we,
  input  logic [latd_pkg::CFG_W-1:0]   cfg_data,
  input  logic [latd_pkg::CHUNK_W-1:0] chunk_index,
  input  logic [latd_pkg::RAW_W-1:0]   raw_node,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [latd_pkg::CHUNK_W-1:0] assigned_chunk,
  output logic                         is_remote,
  output logic                         assigned
);

  import latd_pkg::*;

  localparam int CW = $clog2(MAX_CHUNKS);
  localparam int DW = $clog2(MAX_NODES);

  logic [CFG_W-1:0]      node_count;
  logic [CFG_W-1:0]      eff_nodes;
  logic [DW-1:0]         workers;

  logic [RAW_W-1:0]      node_q;
  logic [CHUNK_W-1:0]    chunk_q;
  logic [RAW_W-1:0]      dividend;
  logic [DW-1:0]         divisor;
  logic [DW-1:0]         rem;
  logic [DW:0]           trial;
  logic [DCNT_W-1:0]     div_cnt;

  logic [MAX_CHUNKS-1:0] pending;
  logic [CW-1:0]         scan_idx;
  logic [CW-1:0]         cmp_idx;
  logic                  cmp_en;
  logic                  found_local;
  logic                  found_any;
  logic [CW-1:0]         local_idx;
  logic [CW-1:0]         any_idx;
  logic [CW-1:0]         pick;

  logic                  in_range;
  logic [CW-1:0]         widx;
  logic [DW-1:0]         home_wdata;
  logic [DW-1:0]         home_rdata;
  logic                  home_match;

  // Clamp the configured node count so the modulus is never zero and every
  // home fits its entry.
  always_comb begin
    if (node_count < NODE_COUNT_MIN) begin
      eff_nodes = NODE_COUNT_MIN;
    end else if (int'(node_count) > MAX_NODES) begin
      eff_nodes = CFG_W'(MAX_NODES);
    end else begin
      eff_nodes = node_count;
    end
  end

  assign workers    = DW'(eff_nodes - CFG_W'(1));
  assign trial      = {rem, dividend[RAW_W-1]};
  assign in_range   = int'(chunk_q) < MAX_CHUNKS;
  assign widx       = CW'(chunk_q);
  assign home_wdata = rem + DW'(1);
  assign home_match = (node_q[RAW_W-1:DW] == '0) && (node_q[DW-1:0] == home_rdata);
  assign pick       = found_local ? local_idx : any_idx;

  assign status.div_done  = (div_cnt == DCNT_W'(DIV_STEPS - 1));
  assign status.scan_last = (scan_idx == CW'(MAX_CHUNKS - 1));
  assign status.out_busy  = out_valid;

  latd_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_CHUNKS)
  ) u_home_ram (
    .clk   (clk),
    .we    (cmd.write_home && in_range),
    .waddr (widx),
    .wdata (home_wdata),
    .raddr (scan_idx),
    .rdata (home_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  // Restoring remainder, one dividend bit per step.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node_q   <= raw_node;
      chunk_q  <= chunk_index;
      dividend <= raw_node;
      divisor  <= workers;
      rem      <= '0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[RAW_W-2:0], 1'b0};
      div_cnt  <= div_cnt + DCNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem <= DW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

  // The scan reads one home entry per cycle; the compare follows in the next
  // cycle, because the RAM read is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en      <= 1'b0;
      found_local <= 1'b0;
      found_any   <= 1'b0;
    end else begin
      cmp_en <= cmd.scan_step;
      if (cmd.capture) begin
        found_local <= 1'b0;
        found_any   <= 1'b0;
      end else if (cmp_en && pending[cmp_idx]) begin
        if (!found_any) begin
          found_any <= 1'b1;
        end
        if (!found_local && home_match) begin
          found_local <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + CW'(1);
    end
    cmp_idx <= scan_idx;
    if (cmp_en && pending[cmp_idx] && !found_any) begin
      any_idx <= cmp_idx;
    end
    if (cmp_en && pending[cmp_idx] && !found_local && home_match) begin
      local_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd.write_home && in_range) begin
      pending[widx] <= 1'b1;
    end else if (cmd.finish && found_any) begin
      pending[pick] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      assigned       <= found_any;
      is_remote      <= found_any && !found_local;
      assigned_chunk <= found_any ? CHUNK_W'(pick) : '0;
    end
  end

endmodule

// ----- hw/rtl/locality_aware_task_dispatch.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_stall    kind, chunk_index, raw_node
// result    out_valid / out_stall  assigned_chunk, is_remote, assigned
// config    cfg_valid / cfg_ready  cfg_data (node_count)
//
// A load runs the 16-step restoring divider, then writes its home entry.
// A request scans the home RAM at one entry per cycle via its single read port.
// Reset is synchronous: it clears every pending bit and sets node_count to 2.
// A result held by out_stall does not block loads; a request waits at its end
// until the output register is free.
module locality_aware_task_dispatch #(
  parameter int MAX_CHUNKS = 64,
  parameter int MAX_NODES  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [latd_pkg::CHUNK_W-1:0] chunk_index,
  input  logic [latd_pkg::RAW_W-1:0]   raw_node,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [latd_pkg::CHUNK_W-1:0] assigned_chunk,
  output logic                         is_remote,
  output logic                         assigned,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [latd_pkg::CFG_W-1:0]   cfg_data
);

  import latd_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  latd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  latd_datapath #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .MAX_NODES  (MAX_NODES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .chunk_index    (chunk_index),
    .raw_node       (raw_node),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .assigned_chunk (assigned_chunk),
    .is_remote      (is_remote),
    .assigned       (assigned)
  );

endmodule

// ----- hw/rtl/latd_checker.sv -----
`include "locality_aware_task_dispatch_defines.svh"

module latd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [latd_pkg::CHUNK_W-1:0] assigned_chunk,
  input logic                         is_remote,
  input logic                         assigned
);

  // Every accepted transaction makes the block busy in the cycle after it is taken.
  `LATD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A new result only comes out at the end of a request the block was busy with.
  `LATD_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall))

  // A held result keeps its payload.
  `LATD_ASSERT_NEXT(a_result_holds, out_valid && out_stall,
                    out_valid && $stable(assigned_chunk) && $stable(is_remote)
                    && $stable(assigned))

endmodule

bind locality_aware_task_dispatch latd_checker u_latd_checker (.*);

// ----- bench/tb.sv -----
module tb;
  import latd_pkg::*;

  localparam int TABLE_SIZE    = 64;
  localparam int NODE_LIMIT    = 16;
  // A request scans the whole table; a load spends most of its time dividing.
  localparam int SETTLE_CYCLES = 90;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 95;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic               remote;
    logic               given;
  } reply_t;

  class dispatch_scoreboard;
    logic [CFG_W-1:0] node_count_q = NODE_COUNT_RESET;
    logic [3:0]       home_q [TABLE_SIZE];
    bit               pending_q [TABLE_SIZE];
    reply_t           replies_due [$];
    int errors, loads, requests, locals, remotes, empties;

    function int worker_count();
      int n;
      n = node_count_q;
      if (n < 2) n = 2;
      if (n > NODE_LIMIT) n = NODE_LIMIT;
      return n - 1;
    endfunction

    // Updates the table for one accepted transaction and queues the reply
    // a request is due to produce.
    function void note_item(logic k, logic [CHUNK_W-1:0] ch, logic [RAW_W-1:0] raw);
      reply_t r;
      int     pick;
      bit     hit;
      if (k == KIND_LOAD) begin
        home_q[ch] = 4'((int'(raw) % worker_count()) + 1);
        pending_q[ch] = 1'b1;
        loads++;
        return;
      end
      requests++;
      pick = -1;
      hit = 1'b0;
      for (int i = 0; i < TABLE_SIZE && pick < 0; i++) begin
        if (pending_q[i] && RAW_W'(home_q[i]) == raw) begin
          pick = i;
          hit = 1'b1;
        end
      end
      for (int i = 0; i < TABLE_SIZE && pick < 0; i++) begin
        if (pending_q[i]) pick = i;
      end
      if (pick < 0) begin
        r = '0;
        empties++;
      end else begin
        pending_q[pick] = 1'b0;
        r.chunk = CHUNK_W'(pick);
        r.remote = !hit;
        r.given = 1'b1;
        if (hit) locals++;
        else remotes++;
      end
      replies_due.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_reply(logic [CHUNK_W-1:0] ch, logic rem, logic asg);
      reply_t want;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply with none outstanding: chunk %0d remote %0b assigned %0b",
                                  ch, rem, asg));
        return;
      end
      want = replies_due.pop_front();
      if (asg !== want.given)
        report_mismatch($sformatf("assigned %0b, predicted %0b", asg, want.given));
      if (ch !== want.chunk)
        report_mismatch($sformatf("assigned_chunk %0d, predicted %0d", ch, want.chunk));
      if (rem !== want.remote)
        report_mismatch($sformatf("is_remote %0b, predicted %0b (chunk %0d)",
                                  rem, want.remote, want.chunk));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               kind = KIND_LOAD;
  logic [CHUNK_W-1:0] chunk_index = '0;
  logic [RAW_W-1:0]   raw_node = '0;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_stall;
  logic               out_valid;
  logic [CHUNK_W-1:0] assigned_chunk;
  logic               is_remote;
  logic               assigned;
  logic               cfg_ready;

  dispatch_scoreboard sb = new;
  int idle_pct = 0;
  int stall_pct = 0;
  int stall_run = 0;
  int quiet_cycles = 0;
  int cfg_writes = 0;

  locality_aware_task_dispatch u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .chunk_index    (chunk_index),
    .raw_node       (raw_node),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .assigned_chunk (assigned_chunk),
    .is_remote      (is_remote),
    .assigned       (assigned),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transactions are sampled at the edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(kind, chunk_index, raw_node);
      if (out_valid && !out_stall) sb.check_reply(assigned_chunk, is_remote, assigned);
      if (cfg_valid && cfg_ready) begin
        sb.node_count_q = cfg_data;
        cfg_writes++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", quiet_cycles);
        $display("locality_aware_task_dispatch: mismatch");
        $finish;
      end
    end
  end

  // Stall runs are capped so the watchdog limit has a known bound.
  always @(posedge clk) begin
    if (stall_run < 40 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run++;
    end else begin
      out_stall <= 1'b0;
      stall_run = 0;
    end
  end

  task automatic send_item(logic k, logic [CHUNK_W-1:0] ch, logic [RAW_W-1:0] raw);
    bit taken;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    chunk_index <= ch;
    raw_node <= raw;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // Loads produce no reply, so the block may still be dividing after the
  // last reply; the settle time covers that.
  task automatic wait_drain();
    @(posedge clk);
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] value);
    bit taken;
    in_valid <= 1'b0;
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] nodes, int mode);
    int               sent;
    int               burst;
    int               w;
    logic [RAW_W-1:0] who;
    write_node_count(nodes);
    idle_pct  = (mode == 1) ? 66 : (mode == 3) ? 15 : 0;
    stall_pct = (mode == 2) ? 66 : (mode == 3) ? 15 : 0;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_item(KIND_LOAD, CHUNK_W'($urandom_range(0, TABLE_SIZE - 1)),
                  $urandom_range(0, 1) ? RAW_W'($urandom_range(0, 40)) : RAW_W'($urandom));
        sent++;
      end
      // Drain the burst, with up to two extra requests to reach the empty table.
      repeat (burst + $urandom_range(0, 2)) begin
        w = sb.worker_count();
        case ($urandom_range(0, 9))
          0:       who = RAW_W'($urandom);
          1:       who = RAW_W'(w + 1 + $urandom_range(0, 2));
          2:       who = '0;
          default: who = RAW_W'($urandom_range(1, w));
        endcase
        send_item(KIND_REQUEST, CHUNK_W'($urandom), who);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item($urandom_range(0, 1) ? KIND_REQUEST : KIND_LOAD, CHUNK_W'($urandom),
                  RAW_W'($urandom));
        sent++;
      end
    end
  endtask

  logic [CFG_W-1:0] phase_nodes [PHASES] = '{5'd31, 5'd3, 5'd1, 5'd16, 5'd9, 5'd17, 5'd2, 5'd15};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: a single worker, so every home is worker 1.
    send_item(KIND_REQUEST, 6'd0, 16'd1);
    send_item(KIND_LOAD, 6'd0, 16'd0);
    send_item(KIND_LOAD, 6'd63, 16'hFFFF);
    send_item(KIND_REQUEST, 6'd63, 16'd1);
    send_item(KIND_REQUEST, 6'd0, 16'd0);
    send_item(KIND_REQUEST, 6'd0, 16'hFFFF);
    send_item(KIND_LOAD, 6'd5, 16'd7);
    send_item(KIND_LOAD, 6'd5, 16'd9);
    send_item(KIND_REQUEST, 6'd0, 16'd1);
    send_item(KIND_REQUEST, 6'd21, 16'd1);

    // Widest setting: fifteen workers.
    write_node_count(5'd16);
    send_item(KIND_LOAD, 6'd10, 16'hFFFF);
    send_item(KIND_LOAD, 6'd3, 16'd14);
    send_item(KIND_LOAD, 6'd20, 16'd15);
    send_item(KIND_REQUEST, 6'd0, 16'd15);
    send_item(KIND_REQUEST, 6'd0, 16'd1);
    send_item(KIND_REQUEST, 6'd0, 16'd16);
    send_item(KIND_REQUEST, 6'd0, 16'd2);

    // A node count of zero must behave as two.
    write_node_count(5'd0);
    send_item(KIND_LOAD, 6'd7, 16'h5555);
    send_item(KIND_LOAD, 6'd2, 16'hAAAA);
    send_item(KIND_REQUEST, 6'd0, 16'd2);
    send_item(KIND_REQUEST, 6'd0, 16'd1);

    for (int p = 0; p < PHASES; p++) run_phase(phase_nodes[p], p % 4);

    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    wait_drain();

    $display("Covered %0d loads and %0d requests across %0d node-count settings.",
             sb.loads, sb.requests, cfg_writes);
    $display("Replies: %0d local, %0d remote, %0d with the table empty; %0d errors.",
             sb.locals, sb.remotes, sb.empties, sb.errors);
    if (sb.errors == 0) begin
      $display("locality_aware_task_dispatch: match");
    end else begin
      $display("locality_aware_task_dispatch: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/latd_pkg.sv
hw/rtl/latd_ram.sv
hw/rtl/latd_ctrl.sv
hw/rtl/latd_datapath.sv
hw/rtl/locality_aware_task_dispatch.sv
hw/rtl/latd_checker.sv
bench/tb.sv
